// ----- sv/ewts_pkg.sv -----
// Shared types and codes for the e-paper waveform temperature selector.
// Holds the band entry layout, state, status, opcode and register codes.
// Used by ewts_mod_unit and epd_waveform_temperature_selector.
package ewts_pkg;

    // One band entry of a temperature table.
    typedef struct packed {
        logic signed [7:0] min_t;
        logic signed [7:0] max_t;
        logic [15:0]       frames;
        logic [23:0]       offset;
    } t_band;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_MATCH    = 2'd0,
        ST_FALLBACK = 2'd1,
        ST_INVALID  = 2'd2,
        ST_WRITE    = 2'd3
    } t_status;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TABLE_VALID   = 2'd0,
        CFG_FULL_COUNT    = 2'd1,
        CFG_PARTIAL_COUNT = 2'd2,
        CFG_PERIOD        = 2'd3
    } t_cfg_idx;

    // Input opcodes.
    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Reset value of the full refresh period.
    localparam logic [7:0] DEFAULT_PERIOD = 8'd10;

    // Status returned by the remainder unit.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_mod_stat;

endpackage

// ----- sv/ewts_mod_unit.sv -----
// Bit-serial remainder unit: tells whether an 8-bit counter is a multiple of the period.
// Restoring division, one dividend bit per cycle.
// Depends on ewts_pkg.
module ewts_mod_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [7:0]            i_dividend,
    input  logic [7:0]            i_divisor,
    output ewts_pkg::t_mod_stat   o_stat
);
    import ewts_pkg::*;

    logic       r_busy;
    logic       r_done;
    logic [2:0] r_step;
    logic [7:0] r_rem;
    logic [7:0] r_dvd;
    logic [7:0] r_div;

    logic [8:0] trial;
    logic [8:0] diff;
    logic       ge;

    // One trial subtraction per cycle.
    assign trial = {r_rem, r_dvd[7]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    // Control: busy for eight steps, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 3'd1;
            if (r_step == 3'd7) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: partial remainder and dividend shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[7:0] : trial[7:0];
            r_dvd <= {r_dvd[6:0], 1'b0};
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == 8'd0);

endmodule

// ----- sv/epd_waveform_temperature_selector.sv -----
// Top level of the e-paper waveform temperature selector.
// Holds the band memory, the configuration registers and the select sequencer.
// Depends on ewts_pkg and ewts_mod_unit.
//
//  channel   direction  handshake                  word
//  input     in         i_valid / o_ready          opcode, temperature, band fields
//  result    out        o_valid / i_ready          wave_frames, wave_offset, used_full_table,
//                                                  status
//  config    in         i_cfg_valid / o_cfg_ready  register index and data
//
// A write word, or a select while the tables are invalid, goes straight to the done
// state and reaches the output register from there; the sequencer then returns to idle.
// A valid select first runs the bit-serial remainder unit that picks the table, then
// reads one band per cycle; the scan stops at the first matching band.
// Its result then passes through the done state to the output register.
// o_ready is high only while the sequencer is idle and out of reset; the result register
// lets a new word be accepted while the previous result still waits for i_ready, and a
// finished word waits in its done state while the output register is full.
// Synchronous reset clears the counter, handshake and config registers (period to 10).
module epd_waveform_temperature_selector #(
    parameter int MAX_BANDS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic signed [7:0]  i_temperature,
    input  logic               i_table_select,
    input  logic [3:0]         i_band_index,
    input  logic signed [7:0]  i_band_min_temp,
    input  logic signed [7:0]  i_band_max_temp,
    input  logic [15:0]        i_band_frames,
    input  logic [23:0]        i_band_offset,
    // Result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_wave_frames,
    output logic [23:0]        o_wave_offset,
    output logic               o_used_full_table,
    output logic [1:0]         o_status,
    // Configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import ewts_pkg::*;

    localparam int DEPTH = 2 * MAX_BANDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_BANDS + 1);

    // Configuration registers.
    logic       r_table_valid;
    logic [4:0] r_full_cnt;
    logic [4:0] r_part_cnt;
    logic [7:0] r_period;

    // Sequencer and select state.
    t_state            r_state;
    t_state            n_state;
    logic [7:0]        r_refresh_cnt;
    logic signed [7:0] r_temp;
    logic              r_use_full;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_iss;
    logic [CW-1:0]     r_rd_num;
    logic              r_rd_vld;
    t_band             r_rd_data;
    t_band             r_b0;

    // Pending result.
    logic [15:0] r_res_frames;
    logic [23:0] r_res_offset;
    logic        r_res_full;
    t_status     r_res_status;

    // Output register.
    logic        r_ovalid;
    logic [15:0] r_o_frames;
    logic [23:0] r_o_offset;
    logic        r_o_full;
    logic [1:0]  r_o_status;

    // Band memory: full table in the lower half, partial table in the upper half.
    t_band mem [0:DEPTH-1];

    logic          in_acc;
    logic          cfg_acc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          mod_start;
    t_mod_stat     mod_stat;
    logic [7:0]    eff_period;
    logic [4:0]    sel_cnt;
    logic [CW-1:0] sat_cnt;
    logic          hit;
    logic          last;
    logic          scan_end;
    logic          out_free;
    t_band         wr_band;

    assign o_ready     = i_rst_n && (r_state == S_IDLE);
    assign o_cfg_ready = i_rst_n && (r_state == S_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_ovalid || i_ready;

    // Band write path.
    assign wr_en         = in_acc && (i_opcode == OP_WRITE) && (int'(i_band_index) < MAX_BANDS);
    assign wr_addr       = AW'(i_table_select ? MAX_BANDS : 0) + AW'(i_band_index);
    assign wr_band.min_t  = i_band_min_temp;
    assign wr_band.max_t  = i_band_max_temp;
    assign wr_band.frames = i_band_frames;
    assign wr_band.offset = i_band_offset;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_band;
        end
    end

    // Scan read path: the band issued last cycle is in r_rd_data.
    assign rd_addr = AW'(r_use_full ? 0 : MAX_BANDS) + AW'(r_iss);

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
    end

    // Table choice: the remainder unit checks counter mod period.
    assign eff_period = (r_period == 8'd0) ? 8'd1 : r_period;
    assign mod_start  = in_acc && (i_opcode == OP_SELECT) && r_table_valid;

    ewts_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_refresh_cnt),
        .i_divisor  (eff_period),
        .o_stat     (mod_stat)
    );

    // Band count of the chosen table, saturated to the table size.
    assign sel_cnt = mod_stat.rem_zero ? r_full_cnt : r_part_cnt;
    assign sat_cnt = (int'(sel_cnt) > MAX_BANDS) ? CW'(MAX_BANDS) : CW'(sel_cnt);

    // Band compare on the word just read.
    assign hit = (r_rd_num < r_count) && (r_temp >= r_rd_data.min_t)
                 && (r_temp < r_rd_data.max_t);
    assign last     = (r_rd_num + CW'(1)) >= r_count;
    assign scan_end = r_rd_vld && (hit || last);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = mod_start ? S_MOD : S_DONE;
                end
            end
            S_MOD: begin
                if (mod_stat.done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_refresh_cnt <= '0;
            r_rd_vld      <= 1'b0;
            r_ovalid      <= 1'b0;
            r_table_valid <= 1'b0;
            r_full_cnt    <= '0;
            r_part_cnt    <= '0;
            r_period      <= DEFAULT_PERIOD;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN) && !scan_end;

            // Counter: cleared by a full refresh, then advanced.
            if (r_state == S_MOD && mod_stat.done) begin
                r_refresh_cnt <= mod_stat.rem_zero ? 8'd1 : r_refresh_cnt + 8'd1;
            end

            // Result register handshake.
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            // Configuration writes.
            if (cfg_acc) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_TABLE_VALID:   r_table_valid <= i_cfg_data[0];
                    CFG_FULL_COUNT:    r_full_cnt    <= i_cfg_data[4:0];
                    CFG_PARTIAL_COUNT: r_part_cnt    <= i_cfg_data[4:0];
                    CFG_PERIOD:        r_period      <= i_cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // Select datapath and pending result.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_temp <= i_temperature;
            r_res_frames <= '0;
            r_res_offset <= '0;
            r_res_full   <= 1'b0;
            r_res_status <= (i_opcode == OP_WRITE) ? ST_WRITE : ST_INVALID;
        end

        if (r_state == S_MOD && mod_stat.done) begin
            r_use_full <= mod_stat.rem_zero;
            r_count    <= sat_cnt;
            r_iss      <= '0;
        end else if (r_state == S_SCAN) begin
            r_iss <= r_iss + CW'(1);
        end
        r_rd_num <= r_iss;

        // Keep band 0 for the fallback answer.
        if (r_rd_vld && r_rd_num == '0) begin
            r_b0 <= r_rd_data;
        end

        if (r_state == S_SCAN && scan_end) begin
            r_res_full <= r_use_full;
            if (hit) begin
                r_res_frames <= r_rd_data.frames;
                r_res_offset <= r_rd_data.offset;
                r_res_status <= ST_MATCH;
            end else if (r_rd_num == '0) begin
                r_res_frames <= r_rd_data.frames;
                r_res_offset <= r_rd_data.offset;
                r_res_status <= ST_FALLBACK;
            end else begin
                r_res_frames <= r_b0.frames;
                r_res_offset <= r_b0.offset;
                r_res_status <= ST_FALLBACK;
            end
        end

        // Load the output register.
        if (r_state == S_DONE && out_free) begin
            r_o_frames <= r_res_frames;
            r_o_offset <= r_res_offset;
            r_o_full   <= r_res_full;
            r_o_status <= r_res_status;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_wave_frames     = r_o_frames;
    assign o_wave_offset     = r_o_offset;
    assign o_used_full_table = r_o_full;
    assign o_status          = r_o_status;

endmodule
